[hw/rtl/sirdx_pkg.sv]
// sirdx_pkg: shared types, constants and helpers for the radix digit writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sirdx_pkg;

  localparam int unsigned NCHARS     = 16;   // digit characters held in the table
  localparam int unsigned CHAR_IDX_W = 4;    // index into the character table
  localparam int unsigned MAX_BASE   = 16;   // largest radix accepted
  localparam int unsigned BASE_W     = 5;    // width of base_size
  localparam int unsigned CFG_W      = 64;   // widest configuration register
  localparam int unsigned CFG_IDX_W  = 2;    // configuration register index
  localparam int unsigned NUM_W      = 32;   // input number width
  localparam int unsigned STEP_BITS  = 8;    // dividend bits consumed per divider pass
  localparam int unsigned DIG_DEPTH  = 32;   // most digits a 32-bit magnitude can need
  localparam int unsigned DIG_IDX_W  = 5;
  localparam int unsigned DIG_CNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HI  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Result of the base scan, handed from the checker to the sequencer.
  typedef struct packed {
    logic done;
    logic ok;
  } chk_t;

  function automatic logic [7:0] digit_char(input logic [8*NCHARS-1:0] tbl,
                                            input logic [CHAR_IDX_W-1:0] idx);
    digit_char = tbl[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sirdx_base_check.sv]
// sirdx_base_check: scans the digit character table, one character per cycle,
// and flags a base that cannot be used. Depends on sirdx_pkg.
`default_nettype none

module sirdx_base_check (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                go,
  input  wire logic [sirdx_pkg::BASE_W-1:0]        base_size,
  input  wire logic [8*sirdx_pkg::NCHARS-1:0]      chars,
  output sirdx_pkg::chk_t                          chk
);
  import sirdx_pkg::*;

  logic                  run_r;
  logic                  done_r;
  logic                  bad_r;
  logic [CHAR_IDX_W-1:0] idx_r;
  logic [7:0]            cur;
  logic                  in_use;
  logic                  dup;
  logic                  hit;

  always_comb begin
    cur    = digit_char(chars, idx_r);
    in_use = {1'b0, idx_r} < base_size;
    dup    = 1'b0;
    for (int j = 0; j < NCHARS; j++) begin
      if ((CHAR_IDX_W'(j) > idx_r) && (BASE_W'(j) < base_size) &&
          (digit_char(chars, CHAR_IDX_W'(j)) == cur)) begin
        dup = 1'b1;
      end
    end
    hit = in_use && (dup || cur == CH_NUL || cur == CH_PLUS || cur == CH_MINUS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      bad_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        idx_r <= '0;
        bad_r <= (base_size < BASE_W'(2)) || (base_size > BASE_W'(MAX_BASE));
      end else if (run_r) begin
        bad_r <= bad_r | hit;
        idx_r <= idx_r + 1'b1;
        if (idx_r == CHAR_IDX_W'(NCHARS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign chk.done = done_r;
  assign chk.ok   = ~bad_r;

endmodule

`default_nettype wire

[hw/rtl/sirdx_div_step.sv]
// sirdx_div_step: one pass of the shared long divider, taking eight dividend
// bits MSB first against a radix of at most 16. Depends on sirdx_pkg.
`default_nettype none

module sirdx_div_step (
  input  wire logic [sirdx_pkg::BASE_W-1:0]     radix,
  input  wire logic [sirdx_pkg::CHAR_IDX_W-1:0] rem_in,
  input  wire logic [sirdx_pkg::STEP_BITS-1:0]  bits_in,
  output logic      [sirdx_pkg::CHAR_IDX_W-1:0] rem_out,
  output logic      [sirdx_pkg::STEP_BITS-1:0]  quo_out
);
  import sirdx_pkg::*;

  logic [BASE_W-1:0] r;

  // Restoring division: the partial remainder stays below the radix.
  always_comb begin
    r       = {1'b0, rem_in};
    quo_out = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      r = {r[BASE_W-2:0], bits_in[k]};
      if (r >= radix) begin
        r          = r - radix;
        quo_out[k] = 1'b1;
      end
    end
    rem_out = r[CHAR_IDX_W-1:0];
  end

endmodule

`default_nettype wire

[hw/rtl/signed_integer_to_radix_digits.sv]
// signed_integer_to_radix_digits: top level, configuration registers, sequencer
// and digit buffer. Depends on sirdx_pkg, sirdx_base_check and sirdx_div_step.
`default_nettype none

// An item is taken when start is high and busy is low; busy then stays high
// until the last character of that item has been issued. Each character is
// presented for exactly one cycle with out_strobe high and must be taken
// then, since the receiver cannot stall. An item first scans the character
// table, one character a cycle, and a rejected base then gives its single
// flagged result. For a usable base, each digit is taken from passes of the
// shared 8-bit-per-pass divider, and once the quotient is zero the '-' of a
// negative number and then the digits, most significant first, are issued.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
module signed_integer_to_radix_digits (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [sirdx_pkg::NUM_W-1:0]  in_number,
  output logic                                     out_strobe,
  output logic             [7:0]                   out_character,
  output logic                                     out_is_last,
  output logic                                     out_base_invalid,
  input  wire logic                                cfg_we,
  input  wire logic        [sirdx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [sirdx_pkg::CFG_W-1:0]  cfg_data
);
  import sirdx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_SIGN, S_EMIT} state_t;

  // Configuration
  logic [BASE_W-1:0]     base_size_r;
  logic [CFG_W-1:0]      chars_lo_r;
  logic [CFG_W-1:0]      chars_hi_r;
  logic [8*NCHARS-1:0]   chars;

  // Sequencer and datapath
  state_t                state_r;
  logic                  neg_r;
  logic [NUM_W-1:0]      div_src_r;
  logic [NUM_W-1:0]      quo_acc_r;
  logic [CHAR_IDX_W-1:0] rem_r;
  logic [1:0]            pass_r;
  logic [DIG_CNT_W-1:0]  nd_r;
  logic [CHAR_IDX_W-1:0] dig_r [DIG_DEPTH];

  logic                  accept;
  logic [NUM_W-1:0]      mag;
  logic [CHAR_IDX_W-1:0] rem_nxt;
  logic [STEP_BITS-1:0]  q_byte;
  logic [NUM_W-1:0]      quo_nxt;
  logic [DIG_IDX_W-1:0]  rd_idx;
  chk_t                  chk;

  logic                  out_strobe_r;
  logic [7:0]            out_character_r;
  logic                  out_is_last_r;
  logic                  out_base_invalid_r;

  assign chars  = {chars_hi_r, chars_lo_r};
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  // Two's complement negate; the most negative value wraps to 2^31 as wanted.
  assign mag    = in_number[NUM_W-1] ? (~in_number + 1'b1) : in_number;
  assign quo_nxt = {quo_acc_r[NUM_W-STEP_BITS-1:0], q_byte};
  assign rd_idx  = nd_r[DIG_IDX_W-1:0] - 1'b1;

  // Write configuration; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= '0;
      chars_lo_r  <= '0;
      chars_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_SIZE: base_size_r <= cfg_data[BASE_W-1:0];
        REG_CHARS_LO:  chars_lo_r  <= cfg_data;
        REG_CHARS_HI:  chars_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sirdx_base_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .base_size (base_size_r),
    .chars     (chars),
    .chk       (chk)
  );

  // The shared divider: one byte of the running quotient a cycle.
  sirdx_div_step u_div (
    .radix   (base_size_r),
    .rem_in  (rem_r),
    .bits_in (div_src_r[NUM_W-1 -: STEP_BITS]),
    .rem_out (rem_nxt),
    .quo_out (q_byte)
  );

  // Datapath registers: divider operands and the digit buffer.
  always_ff @(posedge clk) begin
    if (accept) begin
      div_src_r <= mag;
      rem_r     <= '0;
      neg_r     <= in_number[NUM_W-1];
    end else if (state_r == S_DIV) begin
      quo_acc_r <= quo_nxt;
      if (pass_r == 2'd3) begin
        // Digit complete: stash the remainder, restart on the quotient.
        dig_r[nd_r[DIG_IDX_W-1:0]] <= rem_nxt;
        div_src_r <= quo_nxt;
        rem_r     <= '0;
      end else begin
        div_src_r <= div_src_r << STEP_BITS;
        rem_r     <= rem_nxt;
      end
    end
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      pass_r             <= '0;
      nd_r               <= '0;
      out_strobe_r       <= 1'b0;
      out_character_r    <= '0;
      out_is_last_r      <= 1'b0;
      out_base_invalid_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_CHECK;
            pass_r  <= '0;
            nd_r    <= '0;
          end
        end
        S_CHECK: begin
          if (chk.done) begin
            if (!chk.ok) begin
              // Rejected base: one flagged result, then idle.
              out_strobe_r       <= 1'b1;
              out_character_r    <= CH_NUL;
              out_is_last_r      <= 1'b1;
              out_base_invalid_r <= 1'b1;
              state_r            <= S_IDLE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          pass_r <= pass_r + 1'b1;
          if (pass_r == 2'd3) begin
            nd_r <= nd_r + 1'b1;
            if (quo_nxt == '0) begin
              state_r <= neg_r ? S_SIGN : S_EMIT;
            end
          end
        end
        S_SIGN: begin
          out_strobe_r       <= 1'b1;
          out_character_r    <= CH_MINUS;
          out_is_last_r      <= 1'b0;
          out_base_invalid_r <= 1'b0;
          state_r            <= S_EMIT;
        end
        S_EMIT: begin
          // Issue digits most significant first, reading the buffer backwards.
          out_strobe_r       <= 1'b1;
          out_character_r    <= digit_char(chars, dig_r[rd_idx]);
          out_is_last_r      <= (nd_r == DIG_CNT_W'(1));
          out_base_invalid_r <= 1'b0;
          nd_r               <= nd_r - 1'b1;
          if (nd_r == DIG_CNT_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_character    = out_character_r;
  assign out_is_last      = out_is_last_r;
  assign out_base_invalid = out_base_invalid_r;

  // A rejected base yields a single NUL result that closes the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_base_invalid_r |-> out_is_last_r && out_character_r == CH_NUL)
    else $error("invalid-base result malformed");

  // An accepted item holds the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // Nothing follows the last result of an item in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_is_last_r |=> !out_strobe_r)
    else $error("result after last of item");

  // Digits are only issued while the buffer holds at least one.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> nd_r != '0 && nd_r <= DIG_CNT_W'(DIG_DEPTH))
    else $error("digit buffer count out of range");

endmodule

`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for signed_integer_to_radix_digits.
// Drives numbers and tables of digit characters, predicts every emitted
// character on its own, and depends only on sirdx_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sirdx_pkg::*;

  // Register index that maps to nothing; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Generous limit on the length of the whole run, in cycles.
  localparam int RUN_LIMIT = 600000;

  // One emitted character as the receiver sees it.
  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
    logic       base_invalid;
  } char_rec_t;

  // Ways in which a random table of digit characters may be broken.
  typedef enum int {FLAW_NONE, FLAW_TOO_FEW, FLAW_TOO_MANY, FLAW_REPEAT, FLAW_BAD_CHAR} flaw_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [NUM_W-1:0] in_number = '0;
  logic                 out_strobe;
  logic [7:0]           out_character;
  logic                 out_is_last;
  logic                 out_base_invalid;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Own copy of the configuration, updated as each register is written.
  logic [BASE_W-1:0]        cfg_radix = '0;
  logic [8*NCHARS-1:0]      cfg_chars = '0;

  logic signed [NUM_W-1:0]  numbers_waiting[$];  // items not yet offered
  char_rec_t                expected_chars[$];   // characters still to come
  int                       send_idle_pct = 0;
  bit                       draining = 1'b0;     // sender holds off until all is out
  int                       errors = 0;
  int                       cycles = 0;

  signed_integer_to_radix_digits dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_number        (in_number),
    .out_strobe       (out_strobe),
    .out_character    (out_character),
    .out_is_last      (out_is_last),
    .out_base_invalid (out_base_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [7:0] table_char(input int idx);
    return cfg_chars[8*idx +: 8];
  endfunction

  // A table is usable when its radix is in range and every character in use
  // is distinct and none of them is a NUL or a sign, in any position.
  function automatic bit alphabet_usable();
    int i;
    int j;
    logic [7:0] c;
    if (cfg_radix < 2 || cfg_radix > MAX_BASE) return 1'b0;
    for (i = 0; i < cfg_radix; i++) begin
      c = table_char(i);
      if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS) return 1'b0;
      for (j = i + 1; j < cfg_radix; j++)
        if (table_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Work out the characters one number gives under the current table.
  function automatic void predict_digits(input logic signed [NUM_W-1:0] value);
    logic [32:0] mag;
    logic [32:0] radix;
    logic [7:0]  digs[$];
    int          i;
    if (!alphabet_usable()) begin
      expected_chars.push_back('{CH_NUL, 1'b1, 1'b1});
      return;
    end
    radix = 33'(cfg_radix);
    // Negate at 33 bits so that the most negative number keeps its magnitude.
    mag = value[NUM_W-1] ? 33'd0 - {value[NUM_W-1], value} : {1'b0, value};
    do begin
      digs.push_front(table_char(int'(mag % radix)));
      mag = mag / radix;
    end while (mag != 0);
    if (value[NUM_W-1]) expected_chars.push_back('{CH_MINUS, 1'b0, 1'b0});
    for (i = 0; i < digs.size(); i++)
      expected_chars.push_back('{digs[i], i == digs.size() - 1, 1'b0});
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offer the next number, hold it until busy is low at an edge,
  // and predict its characters on the edge that takes it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_digits(in_number);
        // Now and then pause until every outstanding character is out.
        if ($urandom_range(0, 24) == 0) draining = 1'b1;
      end
      if (draining && expected_chars.size() == 0 && !busy) draining = 1'b0;

      if (start && busy) begin
        // hold the current item until it is taken
      end else if (numbers_waiting.size() != 0 && !draining &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        start     <= 1'b1;
        in_number <= numbers_waiting.pop_front();
      end else begin
        start     <= 1'b0;
        in_number <= $urandom;  // noise on the bus while idle
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe carries a character that must match the oldest
  // prediction; the receiver has no way to stall, so sample every edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    char_rec_t got;
    char_rec_t want;
    if (rst_n && out_strobe === 1'b1) begin
      got = '{out_character, out_is_last, out_base_invalid};
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none,", $time,
                 " actual char %h last %b invalid %b",
                 got.character, got.is_last, got.base_invalid);
      end else begin
        want = expected_chars.pop_front();
        if (got.character !== want.character || got.is_last !== want.is_last ||
            got.base_invalid !== want.base_invalid) begin
          errors++;
          $display("%0t: mismatch: expected char %h last %b invalid %b,", $time,
                   want.character, want.is_last, want.base_invalid,
                   " actual char %h last %b invalid %b",
                   got.character, got.is_last, got.base_invalid);
        end
      end
    end
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d characters outstanding",
               $time, cycles, expected_chars.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------

  // Write one register and mirror it in the local copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= {$urandom, $urandom};
    case (idx)
      REG_BASE_SIZE: cfg_radix = val[BASE_W-1:0];
      REG_CHARS_LO:  cfg_chars[63:0] = val;
      REG_CHARS_HI:  cfg_chars[127:64] = val;
      default: ;  // unmapped index: drop it
    endcase
  endtask

  task automatic load_alphabet(input int radix, input logic [63:0] lo, input logic [63:0] hi);
    write_reg(REG_BASE_SIZE, 64'(radix));
    write_reg(REG_CHARS_LO, lo);
    write_reg(REG_CHARS_HI, hi);
  endtask

  // Let every queued item go in and every character come out, then idle a
  // little so the block is quiet before the next register write.
  task automatic finish_phase();
    do @(negedge clk);
    while (numbers_waiting.size() != 0 || start || busy || expected_chars.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  // Build a random table: mostly usable, sometimes broken on purpose. A
  // nonzero radix_req forces a usable table of that radix.
  task automatic load_random_alphabet(input int radix_req);
    logic [7:0]       chars[NCHARS];
    logic [7:0]       bad_chars[3];
    logic [CFG_W-1:0] reg_val[3];
    logic [CFG_IDX_W-1:0] order[3];
    logic [7:0]       c;
    bit               clash;
    flaw_t            flaw;
    int               n;
    int               i;
    int               j;
    int               rot;
    bad_chars = '{CH_NUL, CH_PLUS, CH_MINUS};
    order = '{REG_BASE_SIZE, REG_CHARS_LO, REG_CHARS_HI};
    n = (radix_req != 0) ? radix_req : $urandom_range(2, MAX_BASE);
    // Unused slots may hold anything, signs and NULs included.
    for (i = 0; i < NCHARS; i++) chars[i] = 8'($urandom);
    for (i = 0; i < n; i++) begin
      do begin
        c = 8'($urandom_range(1, 255));
        clash = (c == CH_PLUS) || (c == CH_MINUS);
        for (j = 0; j < i; j++) if (chars[j] == c) clash = 1'b1;
      end while (clash);
      chars[i] = c;
    end
    i = $urandom_range(0, 9);
    flaw = (radix_req != 0 || i < 6) ? FLAW_NONE : flaw_t'(i - 5);
    case (flaw)
      FLAW_TOO_FEW:  n = $urandom_range(0, 1);
      FLAW_TOO_MANY: n = $urandom_range(MAX_BASE + 1, 31);
      FLAW_REPEAT: begin
        i = $urandom_range(0, n - 1);
        j = $urandom_range(0, n - 2);
        if (j >= i) j++;
        chars[j] = chars[i];
      end
      FLAW_BAD_CHAR: begin
        // Favour the first slot: a sign there must be rejected as well.
        i = $urandom_range(0, 1) ? 0 : $urandom_range(0, n - 1);
        chars[i] = bad_chars[$urandom_range(0, 2)];
      end
      default: ;
    endcase
    reg_val[REG_BASE_SIZE] = {$urandom, $urandom};
    reg_val[REG_BASE_SIZE][BASE_W-1:0] = BASE_W'(n);
    for (i = 0; i < 8; i++) begin
      reg_val[REG_CHARS_LO][8*i +: 8] = chars[i];
      reg_val[REG_CHARS_HI][8*i +: 8] = chars[i + 8];
    end
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    rot = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) write_reg(order[(i + rot) % 3], reg_val[order[(i + rot) % 3]]);
  endtask

  // Random number: full width, short magnitudes of either sign, values near
  // zero, and the extremes.
  function automatic logic signed [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: ;
      3, 4: v = $signed(v) >>> $urandom_range(8, 31);
      5: v = 32'(int'($urandom_range(0, 40)) - 20);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int idle_plan[3];
    int p;
    idle_plan = '{0, 45, 19};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Tables straight out of reset: radix 0, so every number is rejected.
    numbers_waiting.push_back(32'sd5);
    numbers_waiting.push_back(-32'sd5);
    finish_phase();

    // Decimal, with a stray write to the unmapped index first.
    write_reg(REG_UNUSED, '1);
    load_alphabet(10, "76543210", {48'd0, "98"});
    numbers_waiting.push_back(32'sd0);
    numbers_waiting.push_back(32'sd1);
    numbers_waiting.push_back(-32'sd1);
    numbers_waiting.push_back(32'sd9);
    numbers_waiting.push_back(32'sd10);
    numbers_waiting.push_back(-32'sd10);
    numbers_waiting.push_back(32'h7FFF_FFFF);
    numbers_waiting.push_back(32'h8000_0000);
    numbers_waiting.push_back(32'h8000_0001);
    finish_phase();

    // Binary: the most negative number gives the longest output.
    load_alphabet(2, {48'd0, "10"}, 64'd0);
    numbers_waiting.push_back(32'h8000_0000);
    numbers_waiting.push_back(32'h7FFF_FFFF);
    numbers_waiting.push_back(-32'sd1);
    finish_phase();

    // Radix 16 with characters at both ends of the byte range.
    load_alphabet(16, 64'hFF80_7F41_0201_5A33, 64'hC33C_AA55_F00F_E77E);
    numbers_waiting.push_back(32'h7EDC_BA98);
    numbers_waiting.push_back(-32'sd1);
    finish_phase();

    // Rejected tables, one number each.
    load_alphabet(1, "76543210", {48'd0, "98"});          // one character only
    numbers_waiting.push_back(32'sd7);
    finish_phase();
    load_alphabet(17, "76543210", "fedcba98");             // radix beyond the table
    numbers_waiting.push_back(32'sd7);
    finish_phase();
    load_alphabet(31, "76543210", "fedcba98");             // widest radix field
    numbers_waiting.push_back(-32'sd7);
    finish_phase();
    load_alphabet(10, "7654321+", {48'd0, "98"});          // sign in the first slot
    numbers_waiting.push_back(32'sd42);
    finish_phase();
    load_alphabet(16, "76543210", "-edcba98");             // sign in the last slot
    numbers_waiting.push_back(32'sd42);
    finish_phase();
    load_alphabet(10, 64'h3736_3500_3332_3130, {48'd0, "98"}); // NUL in the middle
    numbers_waiting.push_back(32'sd42);
    finish_phase();
    load_alphabet(16, "76543210", "0edcba98");             // repeated character
    numbers_waiting.push_back(32'sd42);
    finish_phase();

    // A sign and NULs beyond the radix are unused and must not matter.
    load_alphabet(10, "76543210", 64'h0000_0000_2D00_3938);
    numbers_waiting.push_back(-32'sd123);
    finish_phase();

    // Random part: a fresh table per phase, the radix extremes first, and
    // the sender's idling varied from phase to phase.
    for (p = 0; p < 12; p++) begin
      send_idle_pct = idle_plan[p % 3];
      load_random_alphabet(p == 0 ? 2 : (p == 1 ? MAX_BASE : 0));
      repeat (26) numbers_waiting.push_back(pick_number());
      finish_phase();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
